// ----- sv/mjsr_pkg.sv -----
// shared types, codes and constants of the mecanum joystick speed ramp
package mjsr_pkg;

  // motion codes, in the order the classifier tests them
  localparam logic [3:0] MOT_STOP = 4'd0;
  localparam logic [3:0] MOT_N    = 4'd1;
  localparam logic [3:0] MOT_S    = 4'd2;
  localparam logic [3:0] MOT_W    = 4'd3;
  localparam logic [3:0] MOT_E    = 4'd4;
  localparam logic [3:0] MOT_NW   = 4'd5;
  localparam logic [3:0] MOT_NE   = 4'd6;
  localparam logic [3:0] MOT_SW   = 4'd7;
  localparam logic [3:0] MOT_SE   = 4'd8;
  localparam logic [3:0] MOT_CW   = 4'd9;
  localparam logic [3:0] MOT_CCW  = 4'd10;
  localparam logic [3:0] MOT_NCW  = 4'd11;
  localparam logic [3:0] MOT_NCCW = 4'd12;
  localparam logic [3:0] MOT_SCW  = 4'd13;
  localparam logic [3:0] MOT_SCCW = 4'd14;

  // register indexes on the configuration port (word address)
  localparam logic [1:0] REG_SPEED_LIMIT = 2'd0;
  localparam logic [1:0] REG_ROT_CW      = 2'd1;
  localparam logic [1:0] REG_ROT_CCW     = 2'd2;

  localparam int AddrW = 4;

  // register reset values
  localparam logic [7:0] SPEED_LIMIT_RST = 8'd64;
  localparam logic [6:0] ROT_CW_RST      = 7'd30;
  localparam logic [7:0] ROT_CCW_RST     = 8'hEC;

  // period constants
  localparam logic [7:0] PERIOD_MAX = 8'd255;
  localparam logic [7:0] STOP_TOP   = 8'd254;
  localparam logic [7:0] STOP_STEP  = 8'd2;

  // command queue between classifier and executor
  localparam int QueueDepth = 2;
  localparam int QueuePtrW  = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int QueueCntW  = $clog2(QueueDepth + 1);

  // square root: two radicand bits per step over a 16-bit radicand
  localparam int SqrtSteps = 8;
  localparam int SqrtCntW  = $clog2(SqrtSteps);

  typedef struct packed {
    logic [7:0] speed_limit;
    logic [6:0] rotate_cw_threshold;
    logic [7:0] rotate_ccw_threshold;
  } cfg_t;

  typedef struct packed {
    logic [3:0]  code;
    logic [7:0]  ax;
    logic [7:0]  ay;
    logic [7:0]  at;
    logic [15:0] sq_sum;
  } cmd_t;

endpackage

// ----- sv/mjsr_stream_if.sv -----
// valid/ready channels for joystick samples and ramp results
interface mjsr_in_if;
  logic              valid;
  logic              ready;
  logic signed [7:0] stick_x;
  logic signed [7:0] stick_y;
  logic signed [7:0] stick_twist;

  modport source (output valid, stick_x, stick_y, stick_twist, input ready);
  modport sink (input valid, stick_x, stick_y, stick_twist, output ready);
endinterface

interface mjsr_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] fast_period;
  logic [7:0] slow_period;
  logic [3:0] wheel_dirs;
  logic [1:0] wheel1_source;
  logic [1:0] wheel2_source;
  logic [1:0] wheel3_source;
  logic [1:0] wheel4_source;
  logic       stop_all_pulse;
  logic [3:0] motion_code;

  modport source (output valid, fast_period, slow_period, wheel_dirs, wheel1_source,
                  wheel2_source, wheel3_source, wheel4_source, stop_all_pulse,
                  motion_code, input ready);
  modport sink (input valid, fast_period, slow_period, wheel_dirs, wheel1_source,
                wheel2_source, wheel3_source, wheel4_source, stop_all_pulse,
                motion_code, output ready);
endinterface

// ----- sv/mjsr_front.sv -----
// front end: classifies a joystick sample into a motion and squares the deflection
module mjsr_front (
  input  logic              clk,
  input  logic              rst,
  mjsr_in_if.sink           sample,
  input  mjsr_pkg::cfg_t    cfg,
  output mjsr_pkg::cmd_t    cmd,
  output logic              cmd_valid,
  input  logic              queue_full
);

  logic             s1_valid;
  logic [3:0]       s1_code;
  logic [7:0]       s1_ax;
  logic [7:0]       s1_ay;
  logic [7:0]       s1_at;
  logic             s2_free;
  logic             s1_move;
  logic             take;

  logic signed [7:0] x;
  logic signed [7:0] y;
  logic signed [7:0] t;
  logic              cw;
  logic              ccw;
  logic [3:0]        code_c;
  logic [15:0]       sq_x;
  logic [15:0]       sq_y;

  assign x = sample.stick_x;
  assign y = sample.stick_y;
  assign t = sample.stick_twist;

  // stage handshakes
  assign s2_free      = !cmd_valid || !queue_full;
  assign s1_move      = s1_valid && s2_free;
  assign sample.ready = !s1_valid || s2_free;
  assign take         = sample.valid && sample.ready;

  // twist thresholds
  assign cw  = $signed({t[7], t}) > $signed({2'b00, cfg.rotate_cw_threshold});
  assign ccw = t < $signed(cfg.rotate_ccw_threshold);

  // motion classification, first match wins
  always_comb begin
    code_c = mjsr_pkg::MOT_STOP;
    if (t == 8'sd0) begin
      if (x == 8'sd0 && y > 8'sd0)      code_c = mjsr_pkg::MOT_N;
      else if (x == 8'sd0 && y < 8'sd0) code_c = mjsr_pkg::MOT_S;
      else if (x < 8'sd0 && y == 8'sd0) code_c = mjsr_pkg::MOT_W;
      else if (x > 8'sd0 && y == 8'sd0) code_c = mjsr_pkg::MOT_E;
      else if (x < 8'sd0 && y > 8'sd0)  code_c = mjsr_pkg::MOT_NW;
      else if (x > 8'sd0 && y > 8'sd0)  code_c = mjsr_pkg::MOT_NE;
      else if (x < 8'sd0 && y < 8'sd0)  code_c = mjsr_pkg::MOT_SW;
      else if (x > 8'sd0 && y < 8'sd0)  code_c = mjsr_pkg::MOT_SE;
    end
    if (code_c == mjsr_pkg::MOT_STOP && x == 8'sd0) begin
      if (y == 8'sd0 && cw)       code_c = mjsr_pkg::MOT_CW;
      else if (y == 8'sd0 && ccw) code_c = mjsr_pkg::MOT_CCW;
      else if (y > 8'sd0 && cw)   code_c = mjsr_pkg::MOT_NCW;
      else if (y > 8'sd0 && ccw)  code_c = mjsr_pkg::MOT_NCCW;
      else if (y < 8'sd0 && cw)   code_c = mjsr_pkg::MOT_SCW;
      else if (y < 8'sd0 && ccw)  code_c = mjsr_pkg::MOT_SCCW;
    end
  end

  // squares of the magnitudes for the diagonal radius
  assign sq_x = 16'(s1_ax) * 16'(s1_ax);
  assign sq_y = 16'(s1_ay) * 16'(s1_ay);

  // stage valids
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      cmd_valid <= 1'b0;
    end else begin
      if (sample.ready) s1_valid <= sample.valid;
      if (s2_free) cmd_valid <= s1_valid;
    end
  end

  // stage payloads
  always_ff @(posedge clk) begin
    if (take) begin
      s1_code <= code_c;
      s1_ax   <= x[7] ? 8'(~x + 8'sd1) : 8'(x);
      s1_ay   <= y[7] ? 8'(~y + 8'sd1) : 8'(y);
      s1_at   <= t[7] ? 8'(~t + 8'sd1) : 8'(t);
    end
    if (s1_move) begin
      cmd.code   <= s1_code;
      cmd.ax     <= s1_ax;
      cmd.ay     <= s1_ay;
      cmd.at     <= s1_at;
      cmd.sq_sum <= sq_x + sq_y;
    end
  end

endmodule

// ----- sv/mjsr_queue.sv -----
// short command queue between the classifier and the executor
module mjsr_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  mjsr_pkg::cmd_t push_cmd,
  input  logic           pop,
  output mjsr_pkg::cmd_t head_cmd,
  output logic           full,
  output logic           empty
);

  mjsr_pkg::cmd_t                      slots [mjsr_pkg::QueueDepth];
  logic [mjsr_pkg::QueuePtrW-1:0]      wr_ptr;
  logic [mjsr_pkg::QueuePtrW-1:0]      rd_ptr;
  logic [mjsr_pkg::QueueCntW-1:0]      count;
  logic                                do_push;
  logic                                do_pop;

  assign full     = count == mjsr_pkg::QueueCntW'(mjsr_pkg::QueueDepth);
  assign empty    = count == '0;
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign head_cmd = slots[rd_ptr];

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == mjsr_pkg::QueuePtrW'(mjsr_pkg::QueueDepth - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == mjsr_pkg::QueuePtrW'(mjsr_pkg::QueueDepth - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) count <= count + 1'b1;
      else if (do_pop && !do_push) count <= count - 1'b1;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (do_push) slots[wr_ptr] <= push_cmd;
  end

endmodule

// ----- sv/mjsr_back.sv -----
// back end: radius square root, period ramp and wheel setup, result register
module mjsr_back (
  input  logic           clk,
  input  logic           rst,
  input  mjsr_pkg::cmd_t q_cmd,
  input  logic           q_empty,
  output logic           q_pop,
  input  mjsr_pkg::cfg_t cfg,
  mjsr_out_if.source     result
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SQRT  = 2'd1;
  localparam logic [1:0] ST_APPLY = 2'd2;

  logic [1:0]                     state;
  mjsr_pkg::cmd_t                 cmd;
  logic [11:0]                    rem;
  logic [7:0]                     root;
  logic [15:0]                    nbits;
  logic [mjsr_pkg::SqrtCntW-1:0]  cnt;

  logic [3:0] last_motion;
  logic [7:0] fast_reg;
  logic [7:0] slow_reg;
  logic [3:0] dir_reg;
  logic [7:0] src_reg;

  logic [3:0] last_next;
  logic [7:0] fast_next;
  logic [7:0] slow_next;
  logic [3:0] dir_next;
  logic [7:0] src_next;
  logic       pulse_next;

  logic [11:0] rem_sh;
  logic [11:0] trial;
  logic        fits;
  logic        diag;
  logic        apply;
  logic [7:0]  sqrt_ceil;
  logic [2:0]  mult;
  logic [7:0]  mag_sel;
  logic [10:0] prod;
  logic [7:0]  fast_t;
  logic [7:0]  slow_t;

  // one step toward the target, decrements only above the limit
  function automatic logic [7:0] ramp(input logic [7:0] cur, input logic [7:0] target,
                                      input logic [7:0] limit);
    logic [7:0] r;
    r = cur;
    if (target < cur && cur > limit) r = cur - 8'd1;
    else if (target > cur) r = cur + 8'd1;
    return r;
  endfunction

  // direction bits touched by each motion
  function automatic logic [3:0] dir_mask(input logic [3:0] code);
    logic [3:0] m;
    case (code) inside
      mjsr_pkg::MOT_NW, mjsr_pkg::MOT_SE: m = 4'h6;
      mjsr_pkg::MOT_NE, mjsr_pkg::MOT_SW: m = 4'h9;
      mjsr_pkg::MOT_STOP:                 m = 4'h0;
      default:                            m = 4'hF;
    endcase
    return m;
  endfunction

  // new values of those direction bits
  function automatic logic [3:0] dir_val(input logic [3:0] code);
    logic [3:0] v;
    case (code) inside
      mjsr_pkg::MOT_N, mjsr_pkg::MOT_NCW, mjsr_pkg::MOT_NCCW: v = 4'hF;
      mjsr_pkg::MOT_W:                                        v = 4'h6;
      mjsr_pkg::MOT_E:                                        v = 4'h9;
      mjsr_pkg::MOT_NW:                                       v = 4'h6;
      mjsr_pkg::MOT_NE:                                       v = 4'h9;
      mjsr_pkg::MOT_CW:                                       v = 4'h5;
      mjsr_pkg::MOT_CCW:                                      v = 4'hA;
      default:                                                v = 4'h0;
    endcase
    return v;
  endfunction

  // timer sources, two bits per wheel, wheel 1 lowest
  function automatic logic [7:0] src_setup(input logic [3:0] code);
    logic [7:0] s;
    case (code) inside
      mjsr_pkg::MOT_NW, mjsr_pkg::MOT_SE:   s = 8'h14;
      mjsr_pkg::MOT_NE, mjsr_pkg::MOT_SW:   s = 8'h41;
      mjsr_pkg::MOT_NCW, mjsr_pkg::MOT_SCW: s = 8'h99;
      mjsr_pkg::MOT_NCCW, mjsr_pkg::MOT_SCCW: s = 8'h66;
      mjsr_pkg::MOT_STOP:                   s = 8'h00;
      default:                              s = 8'h55;
    endcase
    return s;
  endfunction

  assign q_pop = (state == ST_IDLE) && !q_empty;
  assign diag  = (q_cmd.code == mjsr_pkg::MOT_NW) || (q_cmd.code == mjsr_pkg::MOT_NE) ||
                 (q_cmd.code == mjsr_pkg::MOT_SW) || (q_cmd.code == mjsr_pkg::MOT_SE);
  assign apply = (state == ST_APPLY) && (!result.valid || result.ready);

  // one restoring square root step
  assign rem_sh = {rem[9:0], nbits[15:14]};
  assign trial  = {2'b00, root, 2'b01};
  assign fits   = rem_sh >= trial;
  assign sqrt_ceil = root + 8'(rem != 12'd0);

  // multiplier and magnitude per motion
  always_comb begin
    case (cmd.code) inside
      mjsr_pkg::MOT_N, mjsr_pkg::MOT_S, mjsr_pkg::MOT_W, mjsr_pkg::MOT_E: mult = 3'd2;
      mjsr_pkg::MOT_CW:                                                 mult = 3'd1;
      mjsr_pkg::MOT_CCW, mjsr_pkg::MOT_NCW, mjsr_pkg::MOT_SCW:          mult = 3'd3;
      mjsr_pkg::MOT_NCCW:                                               mult = 3'd4;
      mjsr_pkg::MOT_SCCW:                                               mult = 3'd5;
      default:                                                          mult = 3'd0;
    endcase
    case (cmd.code) inside
      mjsr_pkg::MOT_N, mjsr_pkg::MOT_S: mag_sel = cmd.ay;
      mjsr_pkg::MOT_W, mjsr_pkg::MOT_E: mag_sel = cmd.ax;
      default:                          mag_sel = cmd.at;
    endcase
  end

  // targets, modulo 256
  assign prod   = 11'(mult) * 11'(mag_sel);
  assign fast_t = ((cmd.code >= mjsr_pkg::MOT_NW) && (cmd.code <= mjsr_pkg::MOT_SE))
                  ? mjsr_pkg::PERIOD_MAX - sqrt_ceil
                  : mjsr_pkg::PERIOD_MAX - prod[7:0];
  assign slow_t = mjsr_pkg::PERIOD_MAX - {cmd.ay[6:0], 1'b0};

  // state update for one tick
  always_comb begin
    last_next  = last_motion;
    fast_next  = fast_reg;
    slow_next  = slow_reg;
    dir_next   = dir_reg;
    src_next   = src_reg;
    pulse_next = 1'b0;
    if (cmd.code == mjsr_pkg::MOT_STOP) begin
      last_next = mjsr_pkg::MOT_STOP;
      if (fast_reg < mjsr_pkg::STOP_TOP) fast_next = fast_reg + mjsr_pkg::STOP_STEP;
      if (slow_reg < mjsr_pkg::STOP_TOP) slow_next = slow_reg + mjsr_pkg::STOP_STEP;
      if (fast_next >= mjsr_pkg::STOP_TOP && slow_next >= mjsr_pkg::STOP_TOP) begin
        src_next   = 8'h00;
        pulse_next = 1'b1;
      end
    end else begin
      if (cmd.code != last_motion) begin
        last_next  = cmd.code;
        dir_next   = (dir_reg & ~dir_mask(cmd.code)) | dir_val(cmd.code);
        src_next   = src_setup(cmd.code);
        pulse_next = 1'b1;
      end
      fast_next = ramp(fast_reg, fast_t, cfg.speed_limit);
      if (cmd.code >= mjsr_pkg::MOT_NCW) slow_next = ramp(slow_reg, slow_t, cfg.speed_limit);
    end
  end

  // sequencer and motion state
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      last_motion  <= mjsr_pkg::MOT_STOP;
      fast_reg     <= mjsr_pkg::PERIOD_MAX;
      slow_reg     <= mjsr_pkg::PERIOD_MAX;
      dir_reg      <= 4'h0;
      src_reg      <= 8'h00;
      result.valid <= 1'b0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (q_pop) state <= diag ? ST_SQRT : ST_APPLY;
        end
        ST_SQRT: begin
          if (cnt == mjsr_pkg::SqrtCntW'(mjsr_pkg::SqrtSteps - 1)) state <= ST_APPLY;
        end
        ST_APPLY: begin
          if (apply) state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
      if (apply) begin
        last_motion  <= last_next;
        fast_reg     <= fast_next;
        slow_reg     <= slow_next;
        dir_reg      <= dir_next;
        src_reg      <= src_next;
        result.valid <= 1'b1;
      end else if (result.ready) begin
        result.valid <= 1'b0;
      end
    end
  end

  // command capture and square root datapath
  always_ff @(posedge clk) begin
    if (q_pop) begin
      cmd   <= q_cmd;
      rem   <= 12'd0;
      root  <= 8'd0;
      nbits <= q_cmd.sq_sum;
      cnt   <= '0;
    end else if (state == ST_SQRT) begin
      rem   <= fits ? rem_sh - trial : rem_sh;
      root  <= {root[6:0], fits};
      nbits <= {nbits[13:0], 2'b00};
      cnt   <= cnt + 1'b1;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (apply) begin
      result.fast_period    <= fast_next;
      result.slow_period    <= slow_next;
      result.wheel_dirs     <= dir_next;
      result.wheel1_source  <= src_next[1:0];
      result.wheel2_source  <= src_next[3:2];
      result.wheel3_source  <= src_next[5:4];
      result.wheel4_source  <= src_next[7:6];
      result.stop_all_pulse <= pulse_next;
      result.motion_code    <= cmd.code;
    end
  end

endmodule

// ----- sv/mecanum_joystick_speed_ramp.sv -----
// Mecanum joystick speed ramp: one joystick sample per control tick in,
// one wheel setup out (periods, directions, timer sources, stop pulse, motion).
// Channels: sample (stick_x, stick_y, stick_twist) and result, both valid/ready;
// a transaction moves at a rising edge with valid and ready high.
// Configuration: APB write of speed_limit (0x0), rotate_cw_threshold (0x4) and
// rotate_ccw_threshold (0x8); the user writes them only while the block is idle;
// the block does not enforce this. Path: classifier register, command register,
// command queue, executor, result; a diagonal radius goes through an 8-step
// square root (two radicand bits a step). The executor finishes one sample before
// it pops the next; classification runs ahead through a 2-entry command queue.
// The result sits in an output register: a stalled receiver holds it while the
// front end keeps taking samples until the queue and its own registers fill.
// Reset: periods go to 255, directions, sources and last motion to zero,
// registers to their defaults; no result is pending.
module mecanum_joystick_speed_ramp (
  input  logic                         clk,
  input  logic                         rst,
  mjsr_in_if.sink                      sample,
  mjsr_out_if.source                   result,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [mjsr_pkg::AddrW-1:0]   paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);

  mjsr_pkg::cfg_t cfg;
  mjsr_pkg::cmd_t front_cmd;
  mjsr_pkg::cmd_t head_cmd;
  logic           front_valid;
  logic           q_full;
  logic           q_empty;
  logic           q_pop;
  logic           cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.speed_limit          <= mjsr_pkg::SPEED_LIMIT_RST;
      cfg.rotate_cw_threshold  <= mjsr_pkg::ROT_CW_RST;
      cfg.rotate_ccw_threshold <= mjsr_pkg::ROT_CCW_RST;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        mjsr_pkg::REG_SPEED_LIMIT: cfg.speed_limit          <= pwdata[7:0];
        mjsr_pkg::REG_ROT_CW:      cfg.rotate_cw_threshold  <= pwdata[6:0];
        mjsr_pkg::REG_ROT_CCW:     cfg.rotate_ccw_threshold <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  // register readback
  always_comb begin
    case (paddr[3:2])
      mjsr_pkg::REG_SPEED_LIMIT: prdata = {24'd0, cfg.speed_limit};
      mjsr_pkg::REG_ROT_CW:      prdata = {25'd0, cfg.rotate_cw_threshold};
      mjsr_pkg::REG_ROT_CCW:     prdata = {24'd0, cfg.rotate_ccw_threshold};
      default:                   prdata = 32'd0;
    endcase
  end

  mjsr_front u_front (
    .clk        (clk),
    .rst        (rst),
    .sample     (sample),
    .cfg        (cfg),
    .cmd        (front_cmd),
    .cmd_valid  (front_valid),
    .queue_full (q_full)
  );

  mjsr_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (front_valid),
    .push_cmd (front_cmd),
    .pop      (q_pop),
    .head_cmd (head_cmd),
    .full     (q_full),
    .empty    (q_empty)
  );

  mjsr_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_cmd   (head_cmd),
    .q_empty (q_empty),
    .q_pop   (q_pop),
    .cfg     (cfg),
    .result  (result)
  );

`ifndef NO_ASSERTIONS
  // nothing pending right after reset
  a_reset_idle: assert property (@(posedge clk) rst |=> !result.valid)
    else $error("result valid right after reset");

  // a stop pulse while stopped leaves every wheel without a timer
  a_stop_clears: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.stop_all_pulse && result.motion_code == mjsr_pkg::MOT_STOP
    |-> result.wheel1_source == 2'd0 && result.wheel2_source == 2'd0 &&
        result.wheel3_source == 2'd0 && result.wheel4_source == 2'd0)
    else $error("stop pulse with a wheel still driven");

  // the executor only pops a command queue that holds something
  a_queue_pop: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> !q_empty)
    else $error("pop from an empty command queue");

  // a stop pulse while stopped means both periods reached the stop ceiling
  a_stop_rise: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.motion_code == mjsr_pkg::MOT_STOP && result.stop_all_pulse
    |-> result.fast_period >= mjsr_pkg::STOP_TOP && result.slow_period >= mjsr_pkg::STOP_TOP)
    else $error("stop pulse with a period below the ceiling");
`endif

endmodule
